[rtl/round_robin_task_picker_assert.svh]
// Assertion macros shared by the task picker RTL
`ifndef ROUND_ROBIN_TASK_PICKER_ASSERT_SVH
`define ROUND_ROBIN_TASK_PICKER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RRTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rrtp assertion failed");

// next-cycle implication, disabled while reset is held
`define RRTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rrtp assertion failed");

`endif

[rtl/rrtp_pkg.sv]
// Shared types and constants of the round robin task picker
`timescale 1ns / 1ps
`default_nettype none

package rrtp_pkg;

    localparam int RRTP_TASK_SLOTS = 64;

    localparam int TIME_W  = 64;
    localparam int SLICE_W = 8;
    localparam int TPM_W   = 16;
    localparam int DELAY_W = 16;
    localparam int PROD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_KILL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESCHED = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_LIVE = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE     = 2'd3;

    localparam logic CFG_TICKS_PER_MS = 1'b0;
    localparam logic CFG_TIMESLICE    = 1'b1;

    localparam logic [TPM_W-1:0]   TICKS_PER_MS_RST = 16'd1;
    localparam logic [SLICE_W-1:0] TIMESLICE_RST    = 8'd5;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_LIVE   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              running;
        logic [TIME_W-1:0] wake;
    } t_slot_entry;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              due;
    } t_timer_status;

endpackage

`default_nettype wire

[rtl/round_robin_task_picker.sv]
// Round robin task picker: slot table, command sequencer and result register
//
// Hardware scheduler over TASK_SLOTS task slots held in one synchronous slot
// table (kind, running mark and 64-bit wake time per slot, one read and one
// write port, registered read). Requests are taken one at a time and each
// gives exactly one result. After reset a clearing pass writes every slot as
// unused, one slot per cycle, and the block stalls requests until that pass
// ends; configuration writes are taken at any time but must only be issued
// while no request is in flight. Create and resched walk the slot table
// through its single read port, one slot per cycle, and a resched scan goes
// back to slot 0 each time it meets an unused slot past slot 0. A finished
// result waits in the output register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_task_picker_assert.svh"

module round_robin_task_picker import rrtp_pkg::*; #(
    parameter int TASK_SLOTS = RRTP_TASK_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic               i_has_current,
    input  logic [DELAY_W-1:0] i_delay_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOT_W-1:0]  o_result_slot,
    output logic               o_resched_due,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [TPM_W-1:0]   i_cfg_data
);

    localparam int SW  = $clog2(TASK_SLOTS);
    localparam int LW  = $clog2(TASK_SLOTS + 1);
    localparam int STW = $clog2(2 * TASK_SLOTS + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ISSUE  = 7'b0000100,
        S_CREATE = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_clr, n_clr;
    logic [CMD_W-1:0]   r_cmd;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_has_cur;
    logic [PROD_W-1:0]  r_prod;
    logic [SW-1:0]      r_cur, n_cur;
    logic [LW-1:0]      r_seen, n_seen;
    logic [STW-1:0]     r_steps, n_steps;
    logic [LW-1:0]      r_live, n_live;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic               r_due, n_due;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_due;
    logic [TPM_W-1:0]   r_tpm;
    logic [SLICE_W-1:0] r_tslice;

    t_slot_entry        r_mem [TASK_SLOTS];
    t_slot_entry        r_rdata;
    logic               w_mem_we;
    logic [SW-1:0]      w_mem_waddr;
    t_slot_entry        w_mem_wdata;
    logic               w_mem_re;
    logic [SW-1:0]      w_mem_raddr;

    logic               w_accept;
    logic               w_tick;
    logic               w_load_out;
    logic               w_slot_ok;
    logic [SLOT_W:0]    w_slot_inc;
    logic [SW-1:0]      w_start;
    logic [SW-1:0]      w_cur_inc;
    logic               w_cur_last;
    t_timer_status      w_tm;

    rrtp_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_timeslice (r_tslice),
        .o_status    (w_tm)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_slot_ok  = (32'(r_slot) < TASK_SLOTS);
    assign w_slot_inc = {1'b0, r_slot} + (SLOT_W + 1)'(1);
    assign w_start    = (r_has_cur && (32'(w_slot_inc) < TASK_SLOTS)) ? SW'(w_slot_inc) : '0;
    assign w_cur_last = (r_cur == SW'(TASK_SLOTS - 1));
    assign w_cur_inc  = w_cur_last ? '0 : r_cur + SW'(1);
    assign w_tick     = (r_state == S_ISSUE) && (r_cmd == CMD_TICK);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_seen      = r_seen;
        n_steps     = r_steps;
        n_live      = r_live;
        n_status    = r_status;
        n_res_slot  = r_res_slot;
        n_due       = r_due;
        n_out_valid = r_out_valid && i_stall;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_cur;
        w_mem_wdata = r_rdata;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_cur;

        case (r_state)
            S_CLEAR: begin
                w_mem_we         = 1'b1;
                w_mem_waddr      = r_clr;
                w_mem_wdata.kind = KIND_UNUSED;
                w_mem_wdata.running = 1'b0;
                w_mem_wdata.wake = '0;
                n_clr            = r_clr + SW'(1);
                if (r_clr == SW'(TASK_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_status   = ST_OK;
                n_res_slot = '0;
                n_due      = 1'b0;
                n_state    = S_DONE;
                case (r_cmd)
                    CMD_TICK: begin
                        n_due = w_tm.due;
                    end
                    CMD_CREATE: begin
                        n_cur       = '0;
                        w_mem_re    = 1'b1;
                        w_mem_raddr = '0;
                        n_state     = S_CREATE;
                    end
                    CMD_KILL, CMD_YIELD: begin
                        if (w_slot_ok) begin
                            w_mem_re    = 1'b1;
                            w_mem_raddr = SW'(r_slot);
                            n_state     = S_CHECK;
                        end else begin
                            n_status = ST_NOT_LIVE;
                        end
                    end
                    CMD_RESCHED: begin
                        if (r_has_cur && w_slot_ok) begin
                            w_mem_re    = 1'b1;
                            w_mem_raddr = SW'(r_slot);
                            n_state     = S_CHECK;
                        end else begin
                            n_cur   = w_start;
                            n_seen  = '0;
                            n_steps = '0;
                            if (r_live == '0) begin
                                n_status = ST_IDLE;
                            end else begin
                                w_mem_re    = 1'b1;
                                w_mem_raddr = w_start;
                                n_state     = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_CREATE: begin
                if (r_rdata.kind != KIND_LIVE) begin
                    w_mem_we            = 1'b1;
                    w_mem_waddr         = r_cur;
                    w_mem_wdata.kind    = KIND_LIVE;
                    w_mem_wdata.running = 1'b0;
                    w_mem_wdata.wake    = '0;
                    n_live              = r_live + LW'(1);
                    n_status            = ST_OK;
                    n_res_slot          = SLOT_W'(r_cur);
                    n_state             = S_DONE;
                end else if (w_cur_last) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_cur       = w_cur_inc;
                    w_mem_re    = 1'b1;
                    w_mem_raddr = w_cur_inc;
                end
            end
            S_CHECK: begin
                w_mem_waddr = SW'(r_slot);
                n_state     = S_DONE;
                case (r_cmd)
                    CMD_KILL: begin
                        if (r_rdata.kind == KIND_LIVE) begin
                            w_mem_we            = 1'b1;
                            w_mem_wdata.kind    = KIND_EMPTY;
                            w_mem_wdata.running = 1'b0;
                            if (r_live != '0) begin
                                n_live = r_live - LW'(1);
                            end
                        end else begin
                            n_status = ST_NOT_LIVE;
                        end
                    end
                    CMD_YIELD: begin
                        if (r_rdata.kind == KIND_LIVE) begin
                            w_mem_we         = 1'b1;
                            w_mem_wdata.wake = w_tm.now + TIME_W'(r_prod) + TIME_W'(1);
                        end else begin
                            n_status = ST_NOT_LIVE;
                        end
                    end
                    default: begin
                        w_mem_we            = 1'b1;
                        w_mem_wdata.running = 1'b0;
                        n_cur               = w_start;
                        n_seen              = '0;
                        n_steps             = '0;
                        if (r_live == '0) begin
                            n_status = ST_IDLE;
                        end else begin
                            w_mem_re    = 1'b1;
                            w_mem_raddr = w_start;
                            n_state     = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (r_rdata.kind == KIND_UNUSED && r_cur != '0) begin
                    n_cur       = '0;
                    w_mem_re    = 1'b1;
                    w_mem_raddr = '0;
                end else if (r_rdata.kind == KIND_LIVE && r_rdata.wake <= w_tm.now
                             && !r_rdata.running) begin
                    w_mem_we            = 1'b1;
                    w_mem_wdata.running = 1'b1;
                    n_status            = ST_OK;
                    n_res_slot          = SLOT_W'(r_cur);
                    n_state             = S_DONE;
                end else begin
                    n_seen  = r_seen + LW'(r_rdata.kind == KIND_LIVE);
                    n_steps = r_steps + STW'(1);
                    n_cur   = w_cur_inc;
                    if (n_seen < r_live && n_steps < STW'(2 * TASK_SLOTS)) begin
                        w_mem_re    = 1'b1;
                        w_mem_raddr = w_cur_inc;
                    end else begin
                        n_status   = ST_IDLE;
                        n_res_slot = '0;
                        n_state    = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_seen      <= '0;
            r_steps     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_tpm       <= TICKS_PER_MS_RST;
            r_tslice    <= TIMESLICE_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_seen      <= n_seen;
            r_steps     <= n_steps;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TICKS_PER_MS: r_tpm    <= i_cfg_data;
                    CFG_TIMESLICE:    r_tslice <= i_cfg_data[SLICE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_res_slot <= n_res_slot;
        r_due      <= n_due;
        if (w_accept) begin
            r_cmd     <= i_cmd;
            r_slot    <= i_slot;
            r_has_cur <= i_has_current;
            r_prod    <= PROD_W'(i_delay_ms) * PROD_W'(r_tpm);
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_slot   <= r_res_slot;
            r_out_due    <= r_due;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_slot = r_out_slot;
    assign o_resched_due = r_out_due;

    `RRTP_ASSERT_NOW(a_no_same_entry, i_clk, i_rst_n, w_mem_we && w_mem_re, w_mem_waddr != w_mem_raddr)
    `RRTP_ASSERT_NEXT(a_create_counts, i_clk, i_rst_n, r_state == S_CREATE && w_mem_we, r_live == $past(r_live) + LW'(1))
    `RRTP_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n, r_state == S_DONE && r_out_valid && i_stall, r_state == S_DONE)
    `RRTP_ASSERT_NOW(a_scan_bounded, i_clk, i_rst_n, r_state == S_SCAN, r_steps < STW'(2 * TASK_SLOTS))

endmodule

`default_nettype wire

[rtl/rrtp_timer.sv]
// Tick counter and timeslice counter of the task picker
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_task_picker_assert.svh"

module rrtp_timer import rrtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [SLICE_W-1:0] i_timeslice,
    output t_timer_status      o_status
);

    logic [TIME_W-1:0]  r_now;
    logic [SLICE_W-1:0] r_slice;
    logic [SLICE_W-1:0] n_slice_inc;
    logic               w_due;

    assign n_slice_inc = r_slice + SLICE_W'(1);
    assign w_due       = (n_slice_inc >= i_timeslice);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_slice <= '0;
        end else if (i_tick) begin
            r_now   <= r_now + TIME_W'(1);
            r_slice <= w_due ? '0 : n_slice_inc;
        end
    end

    assign o_status.now = r_now;
    assign o_status.due = w_due;

    `RRTP_ASSERT_NEXT(a_now_advances, i_clk, i_rst_n, i_tick, r_now == $past(r_now) + TIME_W'(1))
    `RRTP_ASSERT_NEXT(a_now_holds, i_clk, i_rst_n, !i_tick, $stable(r_now) && $stable(r_slice))
    `RRTP_ASSERT_NEXT(a_slice_restarts, i_clk, i_rst_n, i_tick && w_due, r_slice == '0)

endmodule

`default_nettype wire

[tb/sv/round_robin_task_picker_tb.sv]
// Self-checking testbench for the round robin task picker, with its own scheduler predictor
`timescale 1ns / 1ps

module round_robin_task_picker_tb;
    import rrtp_pkg::*;

    localparam int TASK_SLOTS  = RRTP_TASK_SLOTS;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_WAIT = 300;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic               has_current;
        logic [DELAY_W-1:0] delay_ms;
    } t_sched_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic              due;
    } t_sched_resp;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd         = '0;
    logic [SLOT_W-1:0]  i_slot        = '0;
    logic               i_has_current = 1'b0;
    logic [DELAY_W-1:0] i_delay_ms    = '0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]  o_result_slot;
    logic               o_resched_due;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = 1'b0;
    logic [TPM_W-1:0]   i_cfg_data    = '0;

    round_robin_task_picker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_has_current (i_has_current),
        .i_delay_ms    (i_delay_ms),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_resched_due (o_resched_due),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_kind             slot_state [TASK_SLOTS];
    logic              slot_busy  [TASK_SLOTS];
    logic [TIME_W-1:0] wake_at    [TASK_SLOTS];
    logic [TIME_W-1:0] clock_ticks = '0;
    logic [SLICE_W-1:0] slice_phase = '0;
    int                live_tasks  = 0;
    logic [TPM_W-1:0]  tick_scale  = TICKS_PER_MS_RST;
    logic [SLICE_W-1:0] slice_len  = TIMESLICE_RST;

    t_sched_req  queued_requests [$];
    t_sched_resp pending_outcomes [$];
    t_sched_req  cur_req;

    int idle_pct     = 11;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int cmd_seen [8];
    int odd_cmds     = 0;
    int status_seen [4];
    int due_seen     = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_sched_resp schedule_outcome(input t_sched_req r);
        t_sched_resp o;
        int s;
        int cur;
        int seen;
        int steps;
        bit found;
        o = '0;
        case (r.cmd)
            CMD_TICK: begin
                clock_ticks = clock_ticks + 1;
                slice_phase = slice_phase + 1'b1;
                if (slice_phase >= slice_len) begin
                    slice_phase = '0;
                    o.due = 1'b1;
                end
            end
            CMD_CREATE: begin
                o.status = ST_NO_FREE;
                for (s = 0; s < TASK_SLOTS && o.status == ST_NO_FREE; s++) begin
                    if (slot_state[s] != KIND_LIVE) begin
                        slot_state[s] = KIND_LIVE;
                        slot_busy[s]  = 1'b0;
                        wake_at[s]    = '0;
                        live_tasks++;
                        o.status = ST_OK;
                        o.slot   = SLOT_W'(s);
                    end
                end
            end
            CMD_KILL: begin
                if (int'(r.slot) < TASK_SLOTS && slot_state[r.slot] == KIND_LIVE) begin
                    slot_state[r.slot] = KIND_EMPTY;
                    slot_busy[r.slot]  = 1'b0;
                    if (live_tasks > 0) live_tasks--;
                end else begin
                    o.status = ST_NOT_LIVE;
                end
            end
            CMD_YIELD: begin
                if (int'(r.slot) < TASK_SLOTS && slot_state[r.slot] == KIND_LIVE) begin
                    wake_at[r.slot] = clock_ticks + TIME_W'(r.delay_ms) * TIME_W'(tick_scale) + 1;
                end else begin
                    o.status = ST_NOT_LIVE;
                end
            end
            CMD_RESCHED: begin
                cur = 0;
                if (r.has_current) begin
                    if (int'(r.slot) < TASK_SLOTS) slot_busy[r.slot] = 1'b0;
                    cur = int'(r.slot) + 1;
                end
                if (cur >= TASK_SLOTS) cur = 0;
                seen  = 0;
                steps = 0;
                found = 1'b0;
                while (!found && seen < live_tasks && steps < 2 * TASK_SLOTS) begin
                    if (slot_state[cur] == KIND_UNUSED) cur = 0;
                    if (slot_state[cur] == KIND_LIVE) begin
                        if (wake_at[cur] <= clock_ticks && !slot_busy[cur]) begin
                            slot_busy[cur] = 1'b1;
                            found  = 1'b1;
                            o.slot = SLOT_W'(cur);
                        end else begin
                            seen++;
                        end
                    end
                    if (!found) begin
                        cur++;
                        if (cur >= TASK_SLOTS) cur = 0;
                    end
                    steps++;
                end
                o.status = found ? ST_OK : ST_IDLE;
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    function automatic t_sched_req make_req(input logic [CMD_W-1:0] cmd,
                                            input int slot, input int has_cur,
                                            input int delay);
        t_sched_req r;
        r.cmd         = cmd;
        r.slot        = SLOT_W'(slot);
        r.has_current = (has_cur != 0);
        r.delay_ms    = DELAY_W'(delay);
        return r;
    endfunction

    function automatic t_sched_req random_request(input int create_pct, input int kill_pct);
        t_sched_req r;
        int roll;
        r.slot = ($urandom_range(99) < 60) ? SLOT_W'($urandom_range(15)) : SLOT_W'($urandom);
        r.has_current = ($urandom_range(99) < 75);
        roll = $urandom_range(9);
        if (roll < 4)       r.delay_ms = '0;
        else if (roll < 8)  r.delay_ms = DELAY_W'($urandom_range(20));
        else if (roll == 8) r.delay_ms = DELAY_W'($urandom_range(3));
        else                r.delay_ms = DELAY_W'($urandom);
        roll = $urandom_range(99);
        if (roll < create_pct) begin
            r.cmd = CMD_CREATE;
        end else if (roll < create_pct + kill_pct) begin
            r.cmd = CMD_KILL;
        end else begin
            roll = $urandom_range(99);
            if (roll < 40)      r.cmd = CMD_TICK;
            else if (roll < 62) r.cmd = CMD_YIELD;
            else if (roll < 95) r.cmd = CMD_RESCHED;
            else                r.cmd = CMD_W'($urandom_range({CMD_W{1'b1}}, CMD_RESCHED + 1));
        end
        return r;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || i_valid || pending_outcomes.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [TPM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_TICKS_PER_MS) tick_scale = val;
        else                         slice_len  = val[SLICE_W-1:0];
    endtask

    task automatic run_phase(input int n, input int create_pct, input int kill_pct,
                             input int idle);
        @(negedge i_clk);
        idle_pct = idle;
        repeat (n) queued_requests.push_back(random_request(create_pct, kill_pct));
        wait_idle();
    endtask

    // sender: present queued requests, hold each until taken
    always @(posedge i_clk) begin : drive_requests
        bit give;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_outcomes.push_back(schedule_outcome(cur_req));
                if (cur_req.cmd > CMD_RESCHED) odd_cmds++;
                else                           cmd_seen[cur_req.cmd]++;
            end
            if (!i_valid || !o_stall) begin
                give = queued_requests.size() != 0 && $urandom_range(99) >= idle_pct;
                if (give) begin
                    cur_req = queued_requests.pop_front();
                    i_cmd         <= cur_req.cmd;
                    i_slot        <= cur_req.slot;
                    i_has_current <= cur_req.has_current;
                    i_delay_ms    <= cur_req.delay_ms;
                end
                i_valid <= give;
            end
        end
    end

    // receiver: check each result against the oldest outcome
    always @(posedge i_clk) begin : check_results
        t_sched_resp want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    status_seen[o_status]++;
                    if (o_resched_due === 1'b1) due_seen++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_result_slot !== want.slot) begin
                        $error("result_slot: expected %0d, got %0d", want.slot, o_result_slot);
                        mismatches++;
                    end
                    if (o_resched_due !== want.due) begin
                        $error("resched_due: expected %0d, got %0d", want.due, o_resched_due);
                        mismatches++;
                    end
                end
            end
            i_stall <= $urandom_range(99) < idle_pct;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < TASK_SLOTS; s++) begin
            slot_state[s] = KIND_UNUSED;
            slot_busy[s]  = 1'b0;
            wake_at[s]    = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queued_requests.push_back(make_req(CMD_RESCHED, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_KILL, 0, 1, 0));
        queued_requests.push_back(make_req(CMD_YIELD, 63, 1, 65535));
        repeat (3) queued_requests.push_back(make_req(CMD_CREATE, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_W'(CMD_RESCHED + 1), 63, 1, 65535));
        queued_requests.push_back(make_req(CMD_W'(CMD_RESCHED + 2), 42, 0, 21845));
        queued_requests.push_back(make_req({CMD_W{1'b1}}, 0, 1, 0));
        queued_requests.push_back(make_req(CMD_YIELD, 1, 1, 0));
        queued_requests.push_back(make_req(CMD_YIELD, 2, 0, 65535));
        queued_requests.push_back(make_req(CMD_RESCHED, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_RESCHED, 0, 1, 0));
        repeat (5) queued_requests.push_back(make_req(CMD_TICK, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_RESCHED, 63, 1, 0));
        queued_requests.push_back(make_req(CMD_KILL, 1, 0, 0));
        queued_requests.push_back(make_req(CMD_KILL, 1, 0, 0));
        queued_requests.push_back(make_req(CMD_CREATE, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_RESCHED, 0, 0, 0));
        queued_requests.push_back(make_req(CMD_RESCHED, 2, 1, 0));
        wait_idle();

        write_reg(CFG_TICKS_PER_MS, 16'd1);
        write_reg(CFG_TIMESLICE, 16'd1);
        run_phase(150, 45, 5, 11);

        write_reg(CFG_TICKS_PER_MS, 16'hFFFF);
        write_reg(CFG_TIMESLICE, 16'd255);
        run_phase(150, 15, 15, 11);

        write_reg(CFG_TICKS_PER_MS, TPM_W'($urandom_range(1000, 2)));
        write_reg(CFG_TIMESLICE, TPM_W'($urandom_range(254, 2)));
        run_phase(100, 5, 35, 11);

        write_reg(CFG_TICKS_PER_MS, 16'd3);
        write_reg(CFG_TIMESLICE, 16'd7);
        run_phase(200, 20, 15, 0);

        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("requests: %0d tick, %0d create, %0d kill, %0d yield, %0d resched, %0d unknown",
                 cmd_seen[CMD_TICK], cmd_seen[CMD_CREATE], cmd_seen[CMD_KILL],
                 cmd_seen[CMD_YIELD], cmd_seen[CMD_RESCHED], odd_cmds);
        $display("results: %0d ok, %0d table full, %0d not live, %0d idle, %0d slice expiries",
                 status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_NOT_LIVE],
                 status_seen[ST_IDLE], due_seen);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
